/* rtl/clock_divider_counter_word_defines.svh */
// Assertion macros used by the counter word encoder top level.
`ifndef CLOCK_DIVIDER_COUNTER_WORD_DEFINES_SVH
`define CLOCK_DIVIDER_COUNTER_WORD_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CDCW_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define CDCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cdcw_pkg.sv */
// Constants, derived widths and types for the counter word encoder.
`default_nettype none
package cdcw_pkg;
	localparam int FRAC_BITS = 10;

	localparam int DIV_W   = 8;
	localparam int PHASE_W = 20;
	localparam int DUTY_W  = 17;
	localparam int WORD_W  = 26;
	localparam int P_W     = 19;
	localparam int TIME_W  = 6;
	localparam int HIGH_W  = 7;
	localparam int MUX_W   = 3;
	localparam int NSTAGE  = 5;

	localparam longint unsigned DUTY_LIMIT  = 100000;
	localparam longint unsigned PHASE_LIMIT = 360000;
	localparam longint unsigned MILLI       = 1000;
	localparam longint unsigned FULL_TURN   = 360;

	localparam logic [DUTY_W-1:0]         DUTY_MAX  = DUTY_W'(DUTY_LIMIT);
	localparam logic signed [PHASE_W-1:0] PHASE_LIM = PHASE_W'(PHASE_LIMIT);

	// duty scaling: fix = floor(duty * 2^F / 100000) = (duty * MD) >> SD
	localparam int SD = DUTY_W + $clog2(DUTY_LIMIT);
	localparam longint unsigned MD =
		((64'd1 << (SD + FRAC_BITS)) + DUTY_LIMIT - 1) / DUTY_LIMIT;
	localparam int MD_W = $clog2(MD + 1);
	localparam int PD_W = DUTY_W + MD_W;

	// phase scaling: pf = floor(p * 2^F / 1000) = (p * MP) >> SP
	localparam int SP = P_W + $clog2(MILLI);
	localparam longint unsigned MP =
		((64'd1 << (SP + FRAC_BITS)) + MILLI - 1) / MILLI;
	localparam int MP_W = $clog2(MP + 1);
	localparam int PP_W = P_W + MP_W;
	localparam int PF_W = FRAC_BITS + $clog2(FULL_TURN);

	// high time product and phase product
	localparam int T_W = FRAC_BITS + DIV_W + 1;
	localparam int Y_W = PF_W + DIV_W;

	// turn scaling: c = floor(y / 360) = (y * MC) >> SC
	localparam int SC = Y_W + $clog2(FULL_TURN);
	localparam longint unsigned MC = ((64'd1 << SC) + FULL_TURN - 1) / FULL_TURN;
	localparam int MC_W = $clog2(MC + 1);
	localparam int PC_W = Y_W + MC_W;
	localparam int C_W  = FRAC_BITS + DIV_W + 1;

	typedef struct packed {
		logic [NSTAGE-1:0] en;
		logic [NSTAGE-1:0] vld;
	} pipe_ctl_t;

	typedef struct packed {
		logic              edge_bit;
		logic              nocount;
		logic [TIME_W-1:0] high;
		logic [TIME_W-1:0] low;
	} div_fields_t;

	typedef struct packed {
		logic [MUX_W-1:0]  mux;
		logic [TIME_W-1:0] delay;
	} phase_fields_t;
endpackage
`default_nettype wire

/* rtl/cdcw_ctrl.sv */
// Stage valid bits and per-stage advance enables for the encoder pipeline.
`default_nettype none
module cdcw_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               out_ready,
	output logic              in_ready,
	output cdcw_pkg::pipe_ctl_t ctl
);
	logic [cdcw_pkg::NSTAGE-1:0] vld_q;
	logic [cdcw_pkg::NSTAGE-1:0] en;

	always_comb begin
		en[cdcw_pkg::NSTAGE-1] = !vld_q[cdcw_pkg::NSTAGE-1] || out_ready;
		for (int k = cdcw_pkg::NSTAGE - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < cdcw_pkg::NSTAGE; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready = en[0];
	assign ctl.en   = en;
	assign ctl.vld  = vld_q;
endmodule
`default_nettype wire

/* rtl/cdcw_div_enc.sv */
// Divider part: round high time, apply edge cases, derive low time.
`default_nettype none
module cdcw_div_enc (
	input  wire [cdcw_pkg::T_W-1:0]   t,
	input  wire [cdcw_pkg::DIV_W-1:0] divide,
	input  wire                       duty_err,
	output cdcw_pkg::div_fields_t     fields
);
	localparam int F = cdcw_pkg::FRAC_BITS;

	logic [cdcw_pkg::T_W-1:0]   t_r;
	logic [cdcw_pkg::DIV_W-1:0] high;
	logic [cdcw_pkg::DIV_W-1:0] low;
	logic                       edge_b;

	always_comb begin
		t_r    = t + ({{(cdcw_pkg::T_W-1){1'b0}}, t[F-2]} << (F - 2));
		high   = cdcw_pkg::DIV_W'(t_r[F+cdcw_pkg::HIGH_W-1:F]);
		edge_b = t_r[F-1];
		if (high == '0) begin
			high   = cdcw_pkg::DIV_W'(1);
			edge_b = 1'b0;
		end
		if (high == divide) begin
			high   = divide - cdcw_pkg::DIV_W'(1);
			edge_b = 1'b1;
		end
		low = divide - high;

		fields = '0;
		if (duty_err) begin
			fields = '0;
		end else if (divide == cdcw_pkg::DIV_W'(1)) begin
			fields.high    = cdcw_pkg::TIME_W'(1);
			fields.low     = cdcw_pkg::TIME_W'(1);
			fields.nocount = 1'b1;
		end else begin
			fields.high     = high[cdcw_pkg::TIME_W-1:0];
			fields.low      = low[cdcw_pkg::TIME_W-1:0];
			fields.edge_bit = edge_b;
		end
	end
endmodule
`default_nettype wire

/* rtl/cdcw_phase_enc.sv */
// Phase part: finish the turn scaling, round to eighth steps, split mux and delay.
`default_nettype none
module cdcw_phase_enc (
	input  wire [cdcw_pkg::PC_W-1:0] cprod,
	input  wire                      phase_err,
	output cdcw_pkg::phase_fields_t  fields
);
	localparam int F = cdcw_pkg::FRAC_BITS;

	logic [cdcw_pkg::C_W-1:0] c;
	logic [cdcw_pkg::C_W-1:0] c_r;

	always_comb begin
		c   = {1'b0, cprod[cdcw_pkg::SC+cdcw_pkg::C_W-2:cdcw_pkg::SC]};
		c_r = c + ({{(cdcw_pkg::C_W-1){1'b0}}, c[F-4]} << (F - 4));
		if (phase_err) begin
			fields = '0;
		end else begin
			fields.mux   = c_r[F-1:F-cdcw_pkg::MUX_W];
			fields.delay = c_r[F+cdcw_pkg::TIME_W-1:F];
		end
	end
endmodule
`default_nettype wire

/* rtl/clock_divider_counter_word.sv */
// Top level: five-stage pipeline that encodes divide, phase and duty into a counter word.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   divide_count, phase_millideg, duty_thousandths
//   out      out_valid / out_ready counter_word, duty_error, phase_error
//
// One transaction per cycle while the output is not stalled.
// Stages: input and range checks, scaling multiplies, divide multiplies,
// divider encode with turn multiply, phase encode and packing into the output register.
// Each stage advances when it is empty or its successor advances; a full pipe holds while out_ready is low.
// Reset clears the stage valid bits only.
`default_nettype none
`include "clock_divider_counter_word_defines.svh"
module clock_divider_counter_word (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire [cdcw_pkg::DIV_W-1:0]          divide_count,
	input  wire signed [cdcw_pkg::PHASE_W-1:0] phase_millideg,
	input  wire [cdcw_pkg::DUTY_W-1:0]         duty_thousandths,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [cdcw_pkg::WORD_W-1:0]        counter_word,
	output logic                               duty_error,
	output logic                               phase_error
);
	localparam int F = cdcw_pkg::FRAC_BITS;

	cdcw_pkg::pipe_ctl_t ctl;

	logic signed [cdcw_pkg::PHASE_W-1:0] phase_wrap;
	logic                                perr_in;
	logic                                derr_in;

	logic [cdcw_pkg::DIV_W-1:0]  div_s1, div_s2, div_s3;
	logic [cdcw_pkg::DUTY_W-1:0] duty_s1;
	logic [cdcw_pkg::P_W-1:0]    p_s1;
	logic                        derr_s1, derr_s2, derr_s3, derr_s4, derr_s5;
	logic                        perr_s1, perr_s2, perr_s3, perr_s4, perr_s5;
	logic [cdcw_pkg::PD_W-1:0]   dprod_s2;
	logic [cdcw_pkg::PP_W-1:0]   pprod_s2;
	logic [cdcw_pkg::T_W-1:0]    t_s3;
	logic [cdcw_pkg::Y_W-1:0]    y_s3;
	logic [cdcw_pkg::PC_W-1:0]   cprod_s4;
	cdcw_pkg::div_fields_t       dfld, dfld_s4;
	cdcw_pkg::phase_fields_t     pfld;
	logic [cdcw_pkg::WORD_W-1:0] word_s5;

	cdcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.ctl       (ctl)
	);

	assign perr_in    = (phase_millideg < -cdcw_pkg::PHASE_LIM) ||
		(phase_millideg > cdcw_pkg::PHASE_LIM);
	assign derr_in    = duty_thousandths >= cdcw_pkg::DUTY_MAX;
	assign phase_wrap = phase_millideg[cdcw_pkg::PHASE_W-1] ?
		phase_millideg + cdcw_pkg::PHASE_LIM : phase_millideg;

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			div_s1  <= divide_count;
			duty_s1 <= duty_thousandths;
			p_s1    <= phase_wrap[cdcw_pkg::P_W-1:0];
			derr_s1 <= derr_in;
			perr_s1 <= perr_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			div_s2   <= div_s1;
			dprod_s2 <= cdcw_pkg::PD_W'(duty_s1) * cdcw_pkg::PD_W'(cdcw_pkg::MD);
			pprod_s2 <= cdcw_pkg::PP_W'(p_s1) * cdcw_pkg::PP_W'(cdcw_pkg::MP);
			derr_s2  <= derr_s1;
			perr_s2  <= perr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			div_s3  <= div_s2;
			t_s3    <= cdcw_pkg::T_W'(dprod_s2[cdcw_pkg::SD+F-1:cdcw_pkg::SD]) *
				cdcw_pkg::T_W'(div_s2);
			y_s3    <= cdcw_pkg::Y_W'(pprod_s2[cdcw_pkg::SP+cdcw_pkg::PF_W-1:cdcw_pkg::SP]) *
				cdcw_pkg::Y_W'(div_s2);
			derr_s3 <= derr_s2;
			perr_s3 <= perr_s2;
		end
	end

	cdcw_div_enc u_div_enc (
		.t        (t_s3),
		.divide   (div_s3),
		.duty_err (derr_s3),
		.fields   (dfld)
	);

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			dfld_s4  <= dfld;
			cprod_s4 <= cdcw_pkg::PC_W'(y_s3) * cdcw_pkg::PC_W'(cdcw_pkg::MC);
			derr_s4  <= derr_s3;
			perr_s4  <= perr_s3;
		end
	end

	cdcw_phase_enc u_phase_enc (
		.cprod     (cprod_s4),
		.phase_err (perr_s4),
		.fields    (pfld)
	);

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			word_s5 <= {2'b00, dfld_s4.edge_bit, dfld_s4.nocount, pfld.delay, pfld.mux,
				1'b0, dfld_s4.high, dfld_s4.low};
			derr_s5 <= derr_s4;
			perr_s5 <= perr_s4;
		end
	end

	assign out_valid    = ctl.vld[cdcw_pkg::NSTAGE-1];
	assign counter_word = word_s5;
	assign duty_error   = derr_s5;
	assign phase_error  = perr_s5;

	`CDCW_ASSERT_NOW(a_duty_err_clears, clk, arst_n, out_valid && duty_error,
		(counter_word[11:0] == '0) && (counter_word[23:22] == '0), "duty error with divider bits")
	`CDCW_ASSERT_NOW(a_phase_err_clears, clk, arst_n, out_valid && phase_error,
		counter_word[21:13] == '0, "phase error with phase bits")
	`CDCW_ASSERT_NOW(a_fixed_zero, clk, arst_n, out_valid,
		(counter_word[25:24] == '0) && !counter_word[12], "reserved word bits set")
	`CDCW_ASSERT_NOW(a_stall_full, clk, arst_n, !in_ready,
		(&ctl.vld) && !out_ready, "input held while pipe has room")
	`CDCW_ASSERT_NEXT(a_drain, clk, arst_n, out_valid && out_ready && !ctl.vld[3],
		!out_valid, "result repeated after drain")
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the clock divider counter word encoder.
`timescale 1ns / 1ps
module testbench;
	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 1850;
	localparam int HOLD_CYCLES  = 80;

	typedef struct packed {
		logic [cdcw_pkg::WORD_W-1:0] word;
		logic                        derr;
		logic                        perr;
	} word_result_t;

	typedef struct packed {
		logic [cdcw_pkg::DIV_W-1:0]          div;
		logic signed [cdcw_pkg::PHASE_W-1:0] ph;
		logic [cdcw_pkg::DUTY_W-1:0]         duty;
		logic                                chk;
		word_result_t                        exp;
	} enc_item_t;

	typedef enum int {RX_STREAM, RX_COIN, RX_RARE_STALL, RX_PERIODIC} rx_mode_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [cdcw_pkg::DIV_W-1:0] divide_count;
	logic signed [cdcw_pkg::PHASE_W-1:0] phase_millideg;
	logic [cdcw_pkg::DUTY_W-1:0] duty_thousandths;
	logic out_valid;
	logic out_ready;
	logic [cdcw_pkg::WORD_W-1:0] counter_word;
	logic duty_error;
	logic phase_error;

	logic row_chk;
	word_result_t row_exp;

	word_result_t pending_words[$];
	enc_item_t directed_rows[$];

	int errors = 0;
	int n_accepted = 0;
	int words_checked = 0;
	int n_duty_err = 0;
	int n_phase_err = 0;
	int cycles;
	int burst_left;
	int hold_reqs = 0;

	clock_divider_counter_word uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.divide_count(divide_count),
		.phase_millideg(phase_millideg),
		.duty_thousandths(duty_thousandths),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.counter_word(counter_word),
		.duty_error(duty_error),
		.phase_error(phase_error)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic word_result_t encode_word(input logic [cdcw_pkg::DIV_W-1:0] div,
			input logic signed [cdcw_pkg::PHASE_W-1:0] ph,
			input logic [cdcw_pkg::DUTY_W-1:0] duty);
		word_result_t r;
		logic [63:0] fix, t, hi, lo, p, pf, c;
		logic edge_b, noc;
		longint sph, lim;
		r = '0;
		if (duty >= cdcw_pkg::DUTY_W'(cdcw_pkg::DUTY_LIMIT)) begin
			r.derr = 1'b1;
		end else begin
			if (div == 1) begin
				hi = 1; lo = 1; edge_b = 1'b0; noc = 1'b1;
			end else begin
				fix = (64'(duty) << cdcw_pkg::FRAC_BITS) / cdcw_pkg::DUTY_LIMIT;
				t = fix * 64'(div);
				if (t[cdcw_pkg::FRAC_BITS-2])
					t = t + (64'd1 << (cdcw_pkg::FRAC_BITS - 2));
				hi = (t >> cdcw_pkg::FRAC_BITS) & 64'h7F;
				edge_b = t[cdcw_pkg::FRAC_BITS-1];
				if (hi == 0) begin
					hi = 1; edge_b = 1'b0;
				end
				if (hi == 64'(div)) begin
					hi = 64'(div) - 1; edge_b = 1'b1;
				end
				lo = (64'(div) - hi) & 64'h3F;
				noc = 1'b0;
			end
			r.word[23] = edge_b;
			r.word[22] = noc;
			r.word[11:6] = hi[5:0];
			r.word[5:0] = lo[5:0];
		end
		sph = ph;
		lim = cdcw_pkg::PHASE_LIMIT;
		if (sph < -lim || sph > lim) begin
			r.perr = 1'b1;
		end else begin
			p = (sph < 0) ? 64'(sph + lim) : 64'(sph);
			pf = (p << cdcw_pkg::FRAC_BITS) / cdcw_pkg::MILLI;
			c = (pf * 64'(div)) / cdcw_pkg::FULL_TURN;
			if (c[cdcw_pkg::FRAC_BITS-4])
				c = c + (64'd1 << (cdcw_pkg::FRAC_BITS - 4));
			r.word[15:13] = c[cdcw_pkg::FRAC_BITS-3 +: 3];
			r.word[21:16] = c[cdcw_pkg::FRAC_BITS +: 6];
		end
		return r;
	endfunction

	function automatic enc_item_t row(input logic [cdcw_pkg::DIV_W-1:0] d,
			input logic signed [cdcw_pkg::PHASE_W-1:0] p,
			input logic [cdcw_pkg::DUTY_W-1:0] u, input logic chk,
			input logic [cdcw_pkg::WORD_W-1:0] w, input logic de, input logic pe);
		enc_item_t it;
		it.div = d;
		it.ph = p;
		it.duty = u;
		it.chk = chk;
		it.exp.word = w;
		it.exp.derr = de;
		it.exp.perr = pe;
		return it;
	endfunction

	function automatic enc_item_t random_item();
		enc_item_t it;
		int r;
		it = '0;
		r = $urandom_range(0, 99);
		if (r < 5)
			it.div = 1;
		else if (r < 10)
			it.div = 128;
		else if (r < 80)
			it.div = cdcw_pkg::DIV_W'($urandom_range(2, 127));
		else
			it.div = cdcw_pkg::DIV_W'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 8)
			it.duty = cdcw_pkg::DUTY_W'($urandom_range(100000, 131071));
		else if (r < 12)
			it.duty = $urandom_range(0, 1) ? cdcw_pkg::DUTY_W'(99999) : cdcw_pkg::DUTY_W'(0);
		else if (r < 20)
			it.duty = cdcw_pkg::DUTY_W'($urandom_range(0, 2000));
		else
			it.duty = cdcw_pkg::DUTY_W'($urandom_range(0, 99999));
		r = $urandom_range(0, 99);
		if (r < 4)
			it.ph = cdcw_pkg::PHASE_W'($urandom_range(360001, 524287));
		else if (r < 8)
			it.ph = cdcw_pkg::PHASE_W'(-int'($urandom_range(360001, 524288)));
		else if (r < 14)
			case ($urandom_range(0, 4))
				0: it.ph = 0;
				1: it.ph = cdcw_pkg::PHASE_W'(360000);
				2: it.ph = cdcw_pkg::PHASE_W'(-360000);
				3: it.ph = -1;
				default: it.ph = 1;
			endcase
		else
			it.ph = cdcw_pkg::PHASE_W'(int'($urandom_range(0, 720000)) - 360000);
		return it;
	endfunction

	task automatic offer(input enc_item_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		divide_count <= it.div;
		phase_millideg <= it.ph;
		duty_thousandths <= it.duty;
		row_chk <= it.chk;
		row_exp <= it.exp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
	endtask

	// receiver: stall in segments of differing pattern, plus one long hold-off on request
	initial begin
		rx_mode_t mode;
		int seg, hold_left, k, hold_seen;
		out_ready = 1'b0;
		mode = RX_STREAM;
		seg = 0;
		hold_left = 0;
		k = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			k++;
			if (seg == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				seg = $urandom_range(50, 300);
			end
			seg--;
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					RX_STREAM: out_ready <= 1'b1;
					RX_COIN: out_ready <= 1'($urandom_range(0, 1));
					RX_RARE_STALL: out_ready <= ($urandom_range(0, 9) != 0);
					default: out_ready <= ((k % 7) >= 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		word_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pending_words.push_back(row_chk ? row_exp
					: encode_word(divide_count, phase_millideg, duty_thousandths));
				n_accepted++;
			end
			if (out_valid && out_ready) begin
				if (pending_words.size() == 0) begin
					$display("%0t: result with nothing pending, counter_word %h", $time,
						counter_word);
					errors++;
				end else begin
					want = pending_words.pop_front();
					words_checked++;
					n_duty_err += duty_error;
					n_phase_err += phase_error;
					if (counter_word !== want.word) begin
						$display("%0t: counter_word expected %h got %h", $time, want.word,
							counter_word);
						errors++;
					end
					if (duty_error !== want.derr) begin
						$display("%0t: duty_error expected %b got %b", $time, want.derr,
							duty_error);
						errors++;
					end
					if (phase_error !== want.perr) begin
						$display("%0t: phase_error expected %b got %b", $time, want.perr,
							phase_error);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("clock_divider_counter_word regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		divide_count = '0;
		phase_millideg = '0;
		duty_thousandths = '0;
		row_chk = 1'b0;
		row_exp = '0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_rows.push_back(row(1, 0, 50000, 1, 26'h400041, 0, 0));
		directed_rows.push_back(row(5, 0, 100000, 1, 26'h0, 1, 0));
		directed_rows.push_back(row(5, 360001, 100000, 1, 26'h0, 1, 1));
		directed_rows.push_back(row(5, -360001, 131071, 1, 26'h0, 1, 1));
		directed_rows.push_back(row(0, 0, 0, 1, 26'h7F, 0, 0));
		directed_rows.push_back(row(10, 0, 0, 1, 26'h49, 0, 0));
		directed_rows.push_back(row(2, 0, 50000, 1, 26'h41, 0, 0));
		directed_rows.push_back(row(63, 524287, 0, 1, 26'h7E, 0, 1));
		directed_rows.push_back(row(10, 0, 99999, 0, '0, 0, 0));
		directed_rows.push_back(row(128, 360000, 99999, 0, '0, 0, 0));
		directed_rows.push_back(row(255, -360000, 99999, 0, '0, 0, 0));
		directed_rows.push_back(row(64, 359999, 50000, 0, '0, 0, 0));
		directed_rows.push_back(row(127, -1, 1, 0, '0, 0, 0));
		directed_rows.push_back(row(3, 360000, 33333, 0, '0, 0, 0));
		directed_rows.push_back(row(100, -180000, 75000, 0, '0, 0, 0));
		directed_rows.push_back(row(8, -524288, 65536, 0, '0, 0, 0));
		directed_rows.push_back(row(1, 360000, 0, 0, '0, 0, 0));
		directed_rows.push_back(row(200, 123456, 12345, 0, '0, 0, 0));
		directed_rows.push_back(row(2, 90000, 25000, 0, '0, 0, 0));
		directed_rows.push_back(row(0, -90000, 99999, 0, '0, 0, 0));
		directed_rows.push_back(row(170, 1, 85, 0, '0, 0, 0));
		directed_rows.push_back(row(85, 45000, 42, 0, '0, 0, 0));

		foreach (directed_rows[i]) begin
			offer(directed_rows[i]);
			pace();
		end
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 600)
				hold_reqs++;
			if (i == 1200)
				drain();
			offer(random_item());
			pace();
		end
		drain();
		repeat (2 * cdcw_pkg::NSTAGE + 8) @(negedge clk);

		$display("%0d transactions sent, %0d counter words checked in %0d cycles",
			n_accepted, words_checked, cycles);
		$display("%0d with duty out of range, %0d with phase out of range, %0d mismatches",
			n_duty_err, n_phase_err, errors);
		if (errors == 0 && pending_words.size() == 0)
			$display("clock_divider_counter_word regression: pass");
		else
			$display("clock_divider_counter_word regression: fail");
		$finish;
	end
endmodule
